// File: hw/rtl/scs1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_pkg
// Shared types, key codes and the set 1 key-to-ASCII table for the decoder.
// ----------------------------------------------------------------------------
package scs1_pkg;

  localparam int ScanWidth  = 8;
  localparam int CharWidth  = 7;
  localparam int RowWidth   = 6;
  localparam int InDataWidth  = 8;
  localparam int OutDataWidth = 16;

  // Bytes and key codes of scan code set 1.
  localparam logic [7:0] CODE_PREFIX    = 8'hE0;
  localparam logic [6:0] KEY_LCTRL      = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT     = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT     = 7'h36;
  localparam logic [6:0] KEY_ALT        = 7'h38;
  localparam logic [6:0] KEY_CAPS       = 7'h3A;
  localparam logic [6:0] KEY_LAST       = 7'h3A;

  // One decoded result as it leaves the decoder.
  typedef struct packed {
    logic                 has_result;
    logic [CharWidth-1:0] ascii_char;
    logic                 ctrl_held;
    logic                 alt_held;
  } scs1_result_t;

  // Keys whose shifted column ignores caps lock (digits and punctuation).
  function automatic logic is_symbol_key(input logic [RowWidth-1:0] row);
    logic hit;
    begin
      hit = (row < 6'h0E) || (row == 6'h29) || (row == 6'h1A) || (row == 6'h1B) ||
            (row == 6'h2B) || (row == 6'h27) || (row == 6'h28) || (row == 6'h33) ||
            (row == 6'h34) || (row == 6'h35);
      return hit;
    end
  endfunction

  // Key table: returns {shifted, unshifted}. Modifier rows and unused rows are zero.
  function automatic logic [2*CharWidth-1:0] key_entry(input logic [RowWidth-1:0] row);
    logic [2*CharWidth-1:0] e;
    begin
      case (row)
        6'h01: e = {7'h1B, 7'h1B};
        6'h02: e = {7'h21, 7'h31};
        6'h03: e = {7'h40, 7'h32};
        6'h04: e = {7'h23, 7'h33};
        6'h05: e = {7'h24, 7'h34};
        6'h06: e = {7'h25, 7'h35};
        6'h07: e = {7'h5E, 7'h36};
        6'h08: e = {7'h26, 7'h37};
        6'h09: e = {7'h2A, 7'h38};
        6'h0A: e = {7'h28, 7'h39};
        6'h0B: e = {7'h29, 7'h30};
        6'h0C: e = {7'h5F, 7'h2D};
        6'h0D: e = {7'h2B, 7'h3D};
        6'h0E: e = {7'h08, 7'h08};
        6'h0F: e = {7'h09, 7'h09};
        6'h10: e = {7'h51, 7'h71};
        6'h11: e = {7'h57, 7'h77};
        6'h12: e = {7'h45, 7'h65};
        6'h13: e = {7'h52, 7'h72};
        6'h14: e = {7'h54, 7'h74};
        6'h15: e = {7'h59, 7'h79};
        6'h16: e = {7'h55, 7'h75};
        6'h17: e = {7'h49, 7'h69};
        6'h18: e = {7'h4F, 7'h6F};
        6'h19: e = {7'h50, 7'h70};
        6'h1A: e = {7'h7B, 7'h5B};
        6'h1B: e = {7'h7D, 7'h5D};
        6'h1C: e = {7'h0D, 7'h0D};
        6'h1E: e = {7'h41, 7'h61};
        6'h1F: e = {7'h53, 7'h73};
        6'h20: e = {7'h44, 7'h64};
        6'h21: e = {7'h46, 7'h66};
        6'h22: e = {7'h47, 7'h67};
        6'h23: e = {7'h48, 7'h68};
        6'h24: e = {7'h4A, 7'h6A};
        6'h25: e = {7'h4B, 7'h6B};
        6'h26: e = {7'h4C, 7'h6C};
        6'h27: e = {7'h3A, 7'h3B};
        6'h28: e = {7'h22, 7'h27};
        6'h29: e = {7'h7E, 7'h60};
        6'h2B: e = {7'h7C, 7'h5C};
        6'h2C: e = {7'h5A, 7'h7A};
        6'h2D: e = {7'h58, 7'h78};
        6'h2E: e = {7'h43, 7'h63};
        6'h2F: e = {7'h56, 7'h76};
        6'h30: e = {7'h42, 7'h62};
        6'h31: e = {7'h4E, 7'h6E};
        6'h32: e = {7'h4D, 7'h6D};
        6'h33: e = {7'h3C, 7'h2C};
        6'h34: e = {7'h3E, 7'h2E};
        6'h35: e = {7'h3F, 7'h2F};
        6'h37: e = {7'h2A, 7'h2A};
        6'h39: e = {7'h20, 7'h20};
        default: e = '0;
      endcase
      return e;
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/scs1_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_in_stage
// Input register: captures one scan byte beat and holds it until decoded.
// ----------------------------------------------------------------------------
module scs1_in_stage (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [scs1_pkg::InDataWidth-1:0] in_tdata,
  input  wire logic                           advance,
  output logic                                byte_valid,
  output logic [scs1_pkg::ScanWidth-1:0]      scan_byte
);
  import scs1_pkg::*;

  logic                 valid_r;
  logic                 valid_nxt;
  logic [ScanWidth-1:0] byte_r;

  // Take a new beat when empty or when the held byte moves on this cycle.
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata[ScanWidth-1:0];
    end
  end

  assign byte_valid = valid_r;
  assign scan_byte  = byte_r;

endmodule
`default_nettype wire

// File: hw/rtl/scs1_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_decode
// Keyboard state (prefix, shift, ctrl, alt, caps lock) and byte translation.
// ----------------------------------------------------------------------------
module scs1_decode (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      advance,
  input  wire logic [scs1_pkg::ScanWidth-1:0] scan_byte,
  output scs1_pkg::scs1_result_t         result
);
  import scs1_pkg::*;

  logic prefix_r, shift_r, ctrl_r, alt_r, caps_r;
  logic prefix_nxt, shift_nxt, ctrl_nxt, alt_nxt, caps_nxt;

  logic [6:0]            key;
  logic [RowWidth-1:0]   row;
  logic                  is_break;
  logic                  is_make;
  logic                  col;
  logic [2*CharWidth-1:0] entry;
  logic [CharWidth-1:0]  ch;

  assign key      = scan_byte[6:0];
  assign row      = scan_byte[RowWidth-1:0];
  assign is_break = scan_byte[7];

  // A make code is a base key 01..3A, or extended right ctrl or right alt.
  assign is_make = !is_break &&
                   ((!prefix_r && key != 7'h00 && key <= KEY_LAST) ||
                    (prefix_r && (key == KEY_LCTRL || key == KEY_ALT)));

  // Symbol keys follow shift alone; the rest also follow caps lock.
  assign col   = (!prefix_r && is_symbol_key(row)) ? shift_r : (shift_r ^ caps_r);
  assign entry = key_entry(row);
  assign ch    = col ? entry[2*CharWidth-1:CharWidth] : entry[CharWidth-1:0];

  always_comb begin
    result.has_result = 1'b0;
    result.ascii_char = ch;
    result.ctrl_held  = ctrl_r;
    result.alt_held   = alt_r;
    prefix_nxt = prefix_r;
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    caps_nxt   = caps_r;
    if (scan_byte == CODE_PREFIX) begin
      prefix_nxt = 1'b1;
    end else begin
      prefix_nxt = 1'b0;
      if (is_break) begin
        // Release of a modifier key clears its flag.
        if (key == KEY_LCTRL) begin
          ctrl_nxt = 1'b0;
        end else if (!prefix_r && (key == KEY_LSHIFT || key == KEY_RSHIFT)) begin
          shift_nxt = 1'b0;
        end else if (key == KEY_ALT) begin
          alt_nxt = 1'b0;
        end
      end else if (is_make) begin
        if (ch != '0) begin
          result.has_result = 1'b1;
        end else if (key == KEY_LCTRL) begin
          ctrl_nxt = 1'b1;
        end else if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
          shift_nxt = 1'b1;
        end else if (key == KEY_ALT) begin
          alt_nxt = 1'b1;
        end else if (key == KEY_CAPS) begin
          caps_nxt = !caps_r;
        end
      end
    end
  end

  // State moves only when the held byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 1'b0;
      shift_r  <= 1'b0;
      ctrl_r   <= 1'b0;
      alt_r    <= 1'b0;
      caps_r   <= 1'b0;
    end else if (advance) begin
      prefix_r <= prefix_nxt;
      shift_r  <= shift_nxt;
      ctrl_r   <= ctrl_nxt;
      alt_r    <= alt_nxt;
      caps_r   <= caps_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/scs1_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs1_out_stage
// Output register: holds one character beat until the receiver takes it.
// ----------------------------------------------------------------------------
module scs1_out_stage (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load,
  input  wire scs1_pkg::scs1_result_t            result,
  output logic                                   can_load,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [scs1_pkg::OutDataWidth-1:0]      out_tdata
);
  import scs1_pkg::*;

  logic                      valid_r;
  logic                      valid_nxt;
  logic [OutDataWidth-1:0]   data_r;

  // Register is free when empty or being emptied this cycle.
  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data_r <= {{(OutDataWidth-CharWidth-2){1'b0}}, result.alt_held, result.ctrl_held,
                 result.ascii_char};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

// File: hw/rtl/scancode_set1_to_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// Translates PS/2 scan code set 1 bytes into ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one raw keyboard byte per beat in in_tdata[7:0].
//   The master channel gives one beat for each byte that produces a
//   character: the ASCII code with the current ctrl and alt states. Prefix
//   bytes, break codes, modifier makes and unknown codes produce no beat.
//   A byte accepted into the input register is decoded combinationally and,
//   if it yields a character, loaded into the output register, which then
//   raises out_tvalid. Throughput is one byte per cycle while the output
//   register is not stalled; the decode between the two registers is a
//   table lookup and a few flag updates.
//   Reset (rst_n low, synchronous) clears the prefix, shift, ctrl, alt and
//   caps-lock flags and empties both registers.
//   When the receiver stalls, the output register holds its beat, the input
//   register keeps the next byte, and in_tready drops once both are full.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] scan_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [6:0] ascii_char, [7] ctrl_held, [8] alt_held
);
  import scs1_pkg::*;

  logic                 byte_valid;
  logic [ScanWidth-1:0] scan_byte;
  logic                 can_load;
  logic                 advance;
  scs1_result_t         result;

  // The held byte is consumed when the output register has room.
  assign advance = byte_valid && can_load;

  scs1_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .byte_valid (byte_valid),
    .scan_byte  (scan_byte)
  );

  scs1_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .scan_byte (scan_byte),
    .result    (result)
  );

  scs1_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && result.has_result),
    .result     (result),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // An emitted beat always carries a nonzero character.
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] != 7'h00)
    else $error("output beat with zero character");

  // A prefix byte never produces a beat.
  a_prefix_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && scan_byte == CODE_PREFIX) |-> !result.has_result)
    else $error("prefix byte produced a result");

  // With the output register empty, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // A consumed byte with a result shows up on the output next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.has_result) |=> out_tvalid)
    else $error("decoded result lost");

endmodule
`default_nettype wire
